/* hw/rtl/lpfr_pkg.sv */
// Shared types and constants for the length-prefixed frame receiver.
package lpfr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 64;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned DLEN_W = 7;

  typedef enum logic [1:0] {
    S_LEN_LO  = 2'd0,
    S_LEN_HI  = 2'd1,
    S_PAYLOAD = 2'd2,
    S_DRAIN   = 2'd3
  } lpfr_state_e;

endpackage

/* hw/rtl/lpfr_mem.sv */
// Payload store: one write port, one read port with registered read data.
module lpfr_mem import lpfr_pkg::*; #(
  parameter int unsigned DEPTH = BUFFER_BYTES_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/length_prefixed_frame_receiver.sv */
// Length-prefixed frame receiver: top level with framing control and drain logic.
//
// Input channel rx_*: one channel byte per word. A message is a 16-bit length,
// low byte first, then that many payload bytes. Payload bytes land in a
// BUFFER_BYTES deep store; bytes past capacity are counted and dropped.
// Output channel out_*: one word per delivered payload byte, in order, with
// byte_index, delivered_length (length clipped to capacity), truncated and
// last. A zero-length message gives one word with has_byte low and last high.
// Throughput: one input byte per cycle while a message is being received.
// When the final payload byte is taken, the store is read out one entry per
// cycle through its single read port, registered in the store and then in
// the output register; min(length, BUFFER_BYTES) words are given back to
// back. rx_ready_o stays low for the whole read-out. A zero-length message
// has no read-out.
// A stalled output holds its word in the output register; the read-out
// pauses with it. The high length byte is taken only while the output
// register is free or being emptied.
// Reset clears the framing state (next byte is a length low byte) and drops
// any word not yet taken. The store itself is not cleared.
module length_prefixed_frame_receiver import lpfr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [IDX_W-1:0]  byte_index_o,
  output logic              has_byte_o,
  output logic [DLEN_W-1:0] delivered_length_o,
  output logic              truncated_o,
  output logic              last_o
);

  localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  lpfr_state_e         state_q, state_d;
  logic [LENGTH_W-1:0] len_q, len_d;
  logic [LENGTH_W-1:0] cnt_q, cnt_d;
  logic [DLEN_W-1:0]   dlen_q, dlen_d;
  logic                trunc_q, trunc_d;
  logic [DLEN_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic                rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]    pidx_q;
  logic                out_valid_q, out_valid_d;

  logic [BYTE_W-1:0]   data_q;
  logic [IDX_W-1:0]    idx_q;
  logic                has_q;
  logic [DLEN_W-1:0]   odlen_q;
  logic                otrunc_q;
  logic                last_q;

  logic                slot_free, load_rd, load_zero, acc, rd_en, mem_we, last_rd;
  logic [LENGTH_W-1:0] cnt_inc;
  logic [BYTE_W-1:0]   rdata;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign load_rd    = rd_pend_q && slot_free;
  assign last_rd    = ({1'b0, pidx_q} + DLEN_W'(1)) == dlen_q;
  assign cnt_inc    = cnt_q + LENGTH_W'(1);
  assign rx_ready_o = (state_q == S_LEN_LO) || (state_q == S_PAYLOAD) ||
                      ((state_q == S_LEN_HI) && slot_free);
  assign acc        = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    dlen_d      = dlen_q;
    trunc_d     = trunc_q;
    rd_cnt_d    = rd_cnt_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    load_zero   = 1'b0;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    unique case (state_q)
      S_LEN_LO: begin
        if (acc) begin
          len_d   = {{(LENGTH_W-BYTE_W){1'b0}}, rx_byte_i};
          state_d = S_LEN_HI;
        end
      end
      S_LEN_HI: begin
        if (acc) begin
          len_d = {rx_byte_i, len_q[BYTE_W-1:0]};
          cnt_d = '0;
          if ({rx_byte_i, len_q[BYTE_W-1:0]} == '0) begin
            load_zero   = 1'b1;
            out_valid_d = 1'b1;
            state_d     = S_LEN_LO;
          end else begin
            state_d = S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        if (acc) begin
          mem_we = cnt_q < LENGTH_W'(BUFFER_BYTES);
          cnt_d  = cnt_inc;
          if (cnt_inc >= len_q) begin
            if (len_q > LENGTH_W'(BUFFER_BYTES)) begin
              dlen_d  = DLEN_W'(BUFFER_BYTES);
              trunc_d = 1'b1;
            end else begin
              dlen_d  = len_q[DLEN_W-1:0];
              trunc_d = 1'b0;
            end
            rd_cnt_d = '0;
            state_d  = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        rd_en     = (rd_cnt_q < dlen_q) && (!rd_pend_q || load_rd);
        rd_pend_d = rd_en || (rd_pend_q && !load_rd);
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + DLEN_W'(1);
        end
        if (load_rd) begin
          out_valid_d = 1'b1;
          if (last_rd) begin
            state_d = S_LEN_LO;
          end
        end
      end
      default: state_d = S_LEN_LO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LEN_LO;
      len_q       <= '0;
      cnt_q       <= '0;
      dlen_q      <= '0;
      trunc_q     <= 1'b0;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      dlen_q      <= dlen_d;
      trunc_q     <= trunc_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pidx_q <= rd_cnt_q[IDX_W-1:0];
    end
    if (load_zero) begin
      data_q   <= '0;
      idx_q    <= '0;
      has_q    <= 1'b0;
      odlen_q  <= '0;
      otrunc_q <= 1'b0;
      last_q   <= 1'b1;
    end else if (load_rd) begin
      data_q   <= rdata;
      idx_q    <= pidx_q;
      has_q    <= 1'b1;
      odlen_q  <= dlen_q;
      otrunc_q <= trunc_q;
      last_q   <= last_rd;
    end
  end

  lpfr_mem #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign payload_byte_o     = data_q;
  assign byte_index_o       = idx_q;
  assign has_byte_o         = has_q;
  assign delivered_length_o = odlen_q;
  assign truncated_o        = otrunc_q;
  assign last_o             = last_q;

  a_pend_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> state_q == S_DRAIN)
    else $error("read pending outside drain");

  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN |-> rd_cnt_q <= dlen_q && dlen_q <= DLEN_W'(BUFFER_BYTES))
    else $error("read counter past delivered length");

  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> last_o && delivered_length_o == '0)
    else $error("empty word malformed");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |-> {1'b0, byte_index_o} < delivered_length_o)
    else $error("byte index out of range");

  a_no_rx_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rd |=> out_valid_q)
    else $error("read word lost");

endmodule

/* tb/sv/tb_length_prefixed_frame_receiver.sv */
// Testbench for the length-prefixed frame receiver: directed and random byte stream in, checked words out.
module tb_length_prefixed_frame_receiver;
  import lpfr_pkg::*;

  localparam int unsigned CAPACITY = BUFFER_BYTES_DEF;
  localparam int unsigned CAP_AW = $clog2(CAPACITY);
  localparam int unsigned RANDOM_BYTES = 100;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic              has;
    logic [DLEN_W-1:0] dlen;
    logic              trunc;
    logic              last;
  } frame_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    bit                typed;
    frame_word_t       word;
  } stim_row_t;

  localparam frame_word_t NO_WORD = '0;
  localparam frame_word_t ZERO_LEN_WORD = '{8'h00, 6'd0, 1'b0, 7'd0, 1'b0, 1'b1};
  localparam frame_word_t ONE_FF_WORD = '{8'hFF, 6'd0, 1'b1, 7'd1, 1'b0, 1'b1};
  localparam frame_word_t ONE_00_WORD = '{8'h00, 6'd0, 1'b1, 7'd1, 1'b0, 1'b1};

  localparam int NUM_ROWS = 21;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // zero-length message right after reset
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b1, ZERO_LEN_WORD},
    // single byte, all ones, then all zeros
    '{8'h01, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'hFF, 1'b1, ONE_FF_WORD},
    '{8'h01, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b1, ONE_00_WORD},
    // zero-length messages back to back
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b1, ZERO_LEN_WORD},
    '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b1, ZERO_LEN_WORD},
    '{8'h03, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'hA5, 1'b0, NO_WORD}, '{8'h5A, 1'b0, NO_WORD}, '{8'h3C, 1'b0, NO_WORD},
    '{8'h02, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
    '{8'h80, 1'b0, NO_WORD}, '{8'h7F, 1'b0, NO_WORD}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              rx_valid_i = 1'b0;
  logic              rx_ready_o;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] payload_byte_o;
  logic [IDX_W-1:0]  byte_index_o;
  logic              has_byte_o;
  logic [DLEN_W-1:0] delivered_length_o;
  logic              truncated_o;
  logic              last_o;

  length_prefixed_frame_receiver u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rx_valid_i         (rx_valid_i),
    .rx_ready_o         (rx_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .payload_byte_o     (payload_byte_o),
    .byte_index_o       (byte_index_o),
    .has_byte_o         (has_byte_o),
    .delivered_length_o (delivered_length_o),
    .truncated_o        (truncated_o),
    .last_o             (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Framing predictor state
  lpfr_state_e       frame_phase = S_LEN_LO;
  logic [15:0]       frame_len = '0;
  int unsigned       frame_count = 0;
  logic [BYTE_W-1:0] frame_store [CAPACITY];

  frame_word_t released_words[$];
  frame_word_t due_words[$];
  frame_word_t got_word;
  frame_word_t want_word;

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_accepted = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_roll;
  bit          sink_steady = 1'b0;

  function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] b);
    int unsigned n;
    int unsigned k;
    frame_word_t w;
    released_words.delete();
    case (frame_phase)
      S_LEN_HI: begin
        frame_len[15:8] = b;
        frame_count = 0;
        if (frame_len == 0) begin
          frame_phase = S_LEN_LO;
          released_words.push_back(ZERO_LEN_WORD);
        end else begin
          frame_phase = S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        if (frame_count < CAPACITY) frame_store[frame_count[CAP_AW-1:0]] = b;
        frame_count++;
        if (frame_count >= frame_len) begin
          n = (frame_len > CAPACITY) ? CAPACITY : frame_len;
          for (k = 0; k < n; k++) begin
            w.data  = frame_store[k[CAP_AW-1:0]];
            w.idx   = k[IDX_W-1:0];
            w.has   = 1'b1;
            w.dlen  = n[DLEN_W-1:0];
            w.trunc = (frame_len > CAPACITY);
            w.last  = (k + 1 == n);
            released_words.push_back(w);
          end
          frame_phase = S_LEN_LO;
        end
      end
      default: begin
        frame_len = {8'h00, b};
        frame_phase = S_LEN_HI;
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 0;
    if (roll < 80) return $urandom_range(1, 16);
    if (roll < 92) return $urandom_range(17, CAPACITY);
    return $urandom_range(CAPACITY + 1, 100);
  endfunction

  function automatic void report_mismatch(input string what, input frame_word_t want,
                                          input frame_word_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s: expected data=%h idx=%0d has=%b len=%0d trunc=%b last=%b,",
               what, want.data, want.idx, want.has, want.dlen, want.trunc, want.last);
      $display("  got data=%h idx=%0d has=%b len=%0d trunc=%b last=%b",
               got.data, got.idx, got.has, got.dlen, got.trunc, got.last);
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input int unsigned gap);
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (rx_ready_o !== 1'b1);
    bytes_accepted++;
    absorb_rx_byte(b);
  endtask

  task automatic wait_for_drain();
    rx_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
  endtask

  task automatic send_message(input int unsigned len);
    bit steady;
    int unsigned i;
    logic [BYTE_W-1:0] b;
    steady = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len + 2; i++) begin
      if (i == 0) b = len[7:0];
      else if (i == 1) b = len[15:8];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, steady ? 0 : pick_gap());
      foreach (released_words[j]) due_words.push_back(released_words[j]);
    end
    if ($urandom_range(0, 5) == 0) wait_for_drain();
  endtask

  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ready_i <= 1'b0;
    end else if (sink_steady) begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 63) == 0) sink_steady <= 1'b0;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 4) begin
        sink_steady <= 1'b1;
        out_ready_i <= 1'b1;
      end else if (sink_roll < 70) begin
        out_ready_i <= 1'b1;
      end else if (sink_roll < 95) begin
        out_ready_i <= 1'b0;
        sink_hold <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        sink_hold <= $urandom_range(8, 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word = '{payload_byte_o, byte_index_o, has_byte_o, delivered_length_o,
                   truncated_o, last_o};
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word", NO_WORD, got_word);
      end else begin
        want_word = due_words.pop_front();
        if (got_word.data !== want_word.data || got_word.idx !== want_word.idx ||
            got_word.has !== want_word.has || got_word.dlen !== want_word.dlen ||
            got_word.trunc !== want_word.trunc || got_word.last !== want_word.last)
          report_mismatch("word mismatch", want_word, got_word);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_byte(DIRECTED_ROWS[r].rx, pick_gap());
      if (DIRECTED_ROWS[r].typed) due_words.push_back(DIRECTED_ROWS[r].word);
      else foreach (released_words[j]) due_words.push_back(released_words[j]);
    end
    wait_for_drain();

    // full buffer and one past it
    send_message(CAPACITY);
    send_message(CAPACITY + 1);

    random_start = bytes_accepted;
    while (bytes_accepted - random_start < RANDOM_BYTES) send_message(pick_length());

    rx_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatch_count += due_words.size();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
